[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-gated property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// mhpq_pkg
// Sizes, operation codes, types and the memory port struct of the heap queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = CNT_W + 1;   // holds a child index up to 2*CAPACITY
	localparam int DATA_W   = 32;

	typedef logic [1:0]               func_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [CNT_W-1:0]         count_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic signed [DATA_W-1:0] data_t;

	localparam func_t OP_INSERT = 2'd0;
	localparam func_t OP_DELETE = 2'd1;
	localparam func_t OP_PEEK   = 2'd2;

	localparam data_t EMPTY_VALUE = -32'sd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP,
		ST_UP_ROOT,
		ST_FETCH,
		ST_DOWN
	} state_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		data_t wdata;
		logic  re_a;
		addr_t raddr_a;
		logic  re_b;
		addr_t raddr_b;
	} mem_req_t;

endpackage

[rtl/mhpq_ram.sv]
// ----------------------------------------------------------------------------
// mhpq_ram
// Heap storage: one write port, two registered read ports; read data holds
// while its port is not enabled.
// ----------------------------------------------------------------------------
module mhpq_ram (
	input  logic               clk,
	input  mhpq_pkg::mem_req_t req,
	output mhpq_pkg::data_t    rdata_a,
	output mhpq_pkg::data_t    rdata_b
);
	import mhpq_pkg::*;

	data_t mem_q [CAPACITY];
	data_t rdata_a_q;
	data_t rdata_b_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re_a) begin
			rdata_a_q <= mem_q[req.raddr_a];
		end
		if (req.re_b) begin
			rdata_b_q <= mem_q[req.raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

[rtl/min_heap_priority_queue.sv]
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap priority queue of signed 32-bit values over one RAM.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): func selects insert, delete-minimum or
// peek-minimum; value is used by insert only. Unused codes are swallowed.
// Output channel (out_valid/out_ready): one transaction per delete or peek,
// carrying result_value and was_empty (-1 and was_empty set on an empty queue).
// Insert gives no output; insert on a full queue drops the value.
// One operation is in flight at a time; in_ready is high only when idle.
// Peek: after accept the fetch state loads the result, then the queue is idle.
// Delete: the fetch state loads the result; when entries remain, a sift down
// follows that moves one level per step and ends with a write of the hole value.
// Insert: into an empty queue the root is written at accept; otherwise the
// parent is read and the value climbs one level per up step, with a root step
// at the top. Each level is one RAM read-compare-write, paced by the RAM read.
// A finished result sits in the output register while the next item is
// accepted; only a later delete or peek waits for out_ready before it can
// load its own result. Reset empties the queue at once (fill count cleared);
// RAM contents need no clearing since only entries below the count are used.
// ----------------------------------------------------------------------------
module min_heap_priority_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mhpq_pkg::func_t   func,
	input  mhpq_pkg::data_t   value,
	output logic              out_valid,
	input  logic              out_ready,
	output mhpq_pkg::data_t   result_value,
	output logic              was_empty
);
	import mhpq_pkg::*;

	state_t   state_q, state_d;
	count_t   count_q;
	addr_t    pos_q;
	addr_t    par_q;
	data_t    val_q;
	func_t    func_q;
	logic     out_valid_q;
	data_t    result_q;
	logic     empty_q;

	mem_req_t req;
	data_t    rdata_a, rdata_b;

	mhpq_ram u_ram (
		.clk     (clk),
		.req     (req),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// decisions
	logic   in_acc, is_full, is_empty, can_load;
	addr_t  ins_pos, ins_par, up_par;
	logic   up_less;
	idx_t   left_idx, right_idx;
	logic   left_ok, right_ok, left_lt, right_lt, move_down;
	data_t  left_best, child_data;
	addr_t  best_addr;
	logic [ADDR_W:0] next_left;
	addr_t  next_left_addr, next_right_addr;

	assign in_acc   = in_valid && in_ready;
	assign is_full  = (count_q == count_t'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign can_load = !out_valid_q || out_ready;

	assign ins_pos = count_q[ADDR_W-1:0];
	assign ins_par = addr_t'((count_q - count_t'(1)) >> 1);
	assign up_par  = addr_t'((par_q - addr_t'(1)) >> 1);
	assign up_less = (val_q < rdata_a);

	assign left_idx  = idx_t'({pos_q, 1'b1});
	assign right_idx = left_idx + idx_t'(1);
	assign left_ok   = (left_idx < idx_t'(count_q));
	assign right_ok  = (right_idx < idx_t'(count_q));
	assign left_lt   = left_ok && (rdata_a < val_q);
	assign left_best = left_lt ? rdata_a : val_q;
	// left wins a tie with the right
	assign right_lt  = right_ok && (rdata_b < left_best);
	assign move_down = left_lt || right_lt;
	assign child_data = right_lt ? rdata_b : rdata_a;
	assign best_addr  = right_lt ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
	assign next_left       = {best_addr, 1'b1};
	assign next_left_addr  = next_left[ADDR_W-1:0];
	assign next_right_addr = next_left_addr + addr_t'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (func == OP_INSERT) begin
						if (!is_full && !is_empty) begin
							state_d = ST_UP;
						end
					end else if (func == OP_DELETE || func == OP_PEEK) begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_UP: begin
				if (!up_less) begin
					state_d = ST_IDLE;
				end else if (par_q == '0) begin
					state_d = ST_UP_ROOT;
				end
			end
			ST_UP_ROOT: state_d = ST_IDLE;
			ST_FETCH: begin
				if (can_load) begin
					if (func_q == OP_DELETE && count_q > count_t'(1)) begin
						state_d = ST_DOWN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DOWN: begin
				if (!move_down) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: handshake and memory port
	always_comb begin
		in_ready    = 1'b0;
		req         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_acc) begin
					if (func == OP_INSERT) begin
						if (!is_full && is_empty) begin
							req.we    = 1'b1;
							req.waddr = '0;
							req.wdata = value;
						end else if (!is_full) begin
							req.re_a    = 1'b1;
							req.raddr_a = ins_par;
						end
					end else if (func == OP_DELETE || func == OP_PEEK) begin
						req.re_a    = 1'b1;
						req.raddr_a = '0;
						req.re_b    = 1'b1;
						req.raddr_b = addr_t'(count_q - count_t'(1));
					end
				end
			end
			ST_UP: begin
				req.we    = 1'b1;
				req.waddr = pos_q;
				req.wdata = up_less ? rdata_a : val_q;
				if (up_less && par_q != '0) begin
					req.re_a    = 1'b1;
					req.raddr_a = up_par;
				end
			end
			ST_UP_ROOT: begin
				req.we    = 1'b1;
				req.waddr = '0;
				req.wdata = val_q;
			end
			ST_FETCH: begin
				if (can_load && func_q == OP_DELETE && count_q > count_t'(1)) begin
					req.re_a    = 1'b1;
					req.raddr_a = addr_t'(1);
					req.re_b    = 1'b1;
					req.raddr_b = addr_t'(2);
				end
			end
			ST_DOWN: begin
				req.we    = 1'b1;
				req.waddr = pos_q;
				req.wdata = move_down ? child_data : val_q;
				if (move_down) begin
					req.re_a    = 1'b1;
					req.raddr_a = next_left_addr;
					req.re_b    = 1'b1;
					req.raddr_b = next_right_addr;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FETCH && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && func == OP_INSERT && !is_full) begin
						count_q <= count_q + count_t'(1);
					end
				end
				ST_FETCH: begin
					if (can_load) begin
						if (func_q == OP_DELETE && !is_empty) begin
							count_q <= count_q - count_t'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					func_q <= func;
					val_q  <= value;
					pos_q  <= ins_pos;
					par_q  <= ins_par;
				end
			end
			ST_UP: begin
				if (up_less) begin
					pos_q <= par_q;
					par_q <= up_par;
				end
			end
			ST_FETCH: begin
				if (can_load) begin
					result_q <= is_empty ? EMPTY_VALUE : rdata_a;
					empty_q  <= is_empty;
					// last entry becomes the hole value for the sift down
					val_q    <= rdata_b;
					pos_q    <= '0;
				end
			end
			ST_DOWN: begin
				if (move_down) begin
					pos_q <= best_addr;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign was_empty    = empty_q;

endmodule

[rtl/mhpq_checker.sv]
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks on the heap queue's output channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mhpq_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input mhpq_pkg::data_t result_value,
	input logic            was_empty
);
	import mhpq_pkg::*;

	// hold a stalled transaction
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(result_value) && $stable(was_empty))

	// an empty queue always reports minus one
	`ASSERT_IMPLIES(a_empty_value, out_valid && was_empty, result_value == EMPTY_VALUE)

	// a new result is loaded only while an operation is busy, never from idle
	`ASSERT_IMPLIES(a_result_from_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (.*);
